/* rtl/sbot_pkg.sv */
// sbot_pkg: widths, stage enable and operand types for the segment/box overlap test
// shared by sbot_cross and segment_box_overlap_test; depends on nothing else
package sbot_pkg;

    // coordinate and field sizes
    localparam int COORD_BITS = 32;
    localparam int FIELD_W    = 32;
    localparam int N_FIELDS   = 12;
    localparam int IN_W       = FIELD_W * N_FIELDS;
    localparam int OUT_W      = 8;
    localparam int MARGIN_W   = 16;

    // doubled quantities: midpoint offset, direction, extent, padded |direction|
    localparam int M_W = COORD_BITS + 2;
    localparam int D_W = COORD_BITS + 1;
    localparam int E_W = COORD_BITS + 1;
    localparam int A_W = ((COORD_BITS > MARGIN_W) ? COORD_BITS : MARGIN_W) + 1;

    // cross-axis multiplier operands, second operand split into two halves
    localparam int X_W  = M_W;
    localparam int Y_W  = (D_W > A_W + 1) ? D_W : A_W + 1;
    localparam int LO_W = Y_W / 2;
    localparam int HI_W = Y_W - LO_W;
    localparam int P_W  = X_W + Y_W;
    localparam int S_W  = P_W + 1;

    // advance strobes of the pipeline stages inside the cross-axis unit
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } t_stage_en;

    // operands of one cross-axis test
    typedef struct packed {
        logic signed [X_W-1:0] m1;
        logic signed [X_W-1:0] m2;
        logic signed [X_W-1:0] e1;
        logic signed [X_W-1:0] e2;
        logic signed [Y_W-1:0] d1;
        logic signed [Y_W-1:0] d2;
        logic signed [Y_W-1:0] a1;
        logic signed [Y_W-1:0] a2;
    } t_cross_ops;

endpackage

/* rtl/segment_box_overlap_test.sv */
// segment_box_overlap_test: separating-axis overlap test of a 3D segment and a box
// top level, seven register stages; uses sbot_pkg and sbot_cross
//
//  channel   direction  handshake                     content
//  s_axis    in         s_axis_tvalid/s_axis_tready   segment ends and box corners
//  m_axis    out        m_axis_tvalid/m_axis_tready   overlap flag
//  cfg       in         i_cfg_valid/o_cfg_ready       axis margin (16 bits, reset 1)
//
// one request per cycle unless an output stall has filled the stages back to stage 1; a
// result passes through the stage registers and can leave once it reaches the output register
// stages: doubled sums, face tests, split partial products, products, cross sides,
// cross compare, output register; valid bits follow the data through every stage
// a stage with no data takes a new request even while the output waits, so bubbles
// close up under a stall; nothing is dropped or repeated
// reset (i_rst_n low at a clock edge) clears all valid bits and sets the margin to 1
module segment_box_overlap_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request: seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y,
    // seg_end_z, box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z
    // (32 bits each, lowest bits first)
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sbot_pkg::IN_W-1:0]     s_axis_tdata,
    // result: overlaps in bit 0, remaining bits zero
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sbot_pkg::OUT_W-1:0]    m_axis_tdata,
    // margin write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sbot_pkg::MARGIN_W-1:0] i_cfg_data
);
    import sbot_pkg::*;

    localparam int N_STAGES = 7;

    logic                         r_vld [1:N_STAGES];
    logic                         w_en  [1:N_STAGES];
    logic [MARGIN_W-1:0]          r_margin;

    logic signed [COORD_BITS-1:0] w_s [3];
    logic signed [COORD_BITS-1:0] w_t [3];
    logic signed [COORD_BITS-1:0] w_lo [3];
    logic signed [COORD_BITS-1:0] w_hi [3];

    logic signed [M_W-1:0]        r_m1 [3];
    logic signed [D_W-1:0]        r_d1 [3];
    logic signed [E_W-1:0]        r_e1 [3];

    logic        [M_W-1:0]        w_abs_m [3];
    logic        [D_W-1:0]        w_abs_d [3];
    logic signed [M_W-1:0]        w_lim [3];
    logic        [2:0]            w_face;

    logic signed [M_W-1:0]        r_m2 [3];
    logic signed [D_W-1:0]        r_d2 [3];
    logic signed [E_W-1:0]        r_e2 [3];
    logic        [A_W-1:0]        r_a2 [3];
    logic                         r_face [2:6];

    t_stage_en                    w_stage_en;
    t_cross_ops                   w_ops [3];
    logic        [2:0]            w_sep;
    logic                         r_ovl;

    // margin register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_W'(1);
        end else if (i_cfg_valid) begin
            r_margin <= i_cfg_data;
        end
    end

    // stage advance: a stage loads when it is empty or its content moves on
    always_comb begin
        w_en[N_STAGES] = !r_vld[N_STAGES] || m_axis_tready;
        for (int k = N_STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= N_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= N_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // field unpacking, low coordinate bits of each field
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s[i]  = s_axis_tdata[FIELD_W*i       +: COORD_BITS];
            w_t[i]  = s_axis_tdata[FIELD_W*(3+i)   +: COORD_BITS];
            w_lo[i] = s_axis_tdata[FIELD_W*(6+i)   +: COORD_BITS];
            w_hi[i] = s_axis_tdata[FIELD_W*(9+i)   +: COORD_BITS];
        end
    end

    // stage 1: doubled midpoint offset, direction and extent
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_m1[i] <= M_W'(w_s[i]) + M_W'(w_t[i]) - M_W'(w_lo[i]) - M_W'(w_hi[i]);
                r_d1[i] <= D_W'(w_t[i]) - D_W'(w_s[i]);
                r_e1[i] <= E_W'(w_hi[i]) - E_W'(w_lo[i]);
            end
        end
    end

    // stage 2: face tests |m| > e + |d|, padded |d| for the cross tests
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs_m[i] = r_m1[i][M_W-1] ? M_W'(-r_m1[i]) : M_W'(r_m1[i]);
            w_abs_d[i] = r_d1[i][D_W-1] ? D_W'(-r_d1[i]) : D_W'(r_d1[i]);
            w_lim[i]   = M_W'(r_e1[i]) + M_W'(w_abs_d[i]);
            w_face[i]  = $signed({1'b0, w_abs_m[i]}) > $signed({w_lim[i][M_W-1], w_lim[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_m2[i] <= r_m1[i];
                r_d2[i] <= r_d1[i];
                r_e2[i] <= r_e1[i];
                r_a2[i] <= A_W'(w_abs_d[i]) + A_W'(r_margin);
            end
        end
    end

    // face result, taken at stage 2 and riding alongside the cross-axis stages
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_face[2] <= |w_face;
        end
        for (int k = 3; k <= 6; k++) begin
            if (w_en[k]) begin
                r_face[k] <= r_face[k-1];
            end
        end
    end

    // stages 3 to 6: three cross-axis tests, axis g pairs components g+1 and g+2
    assign w_stage_en = '{en3: w_en[3], en4: w_en[4], en5: w_en[5], en6: w_en[6]};

    for (genvar g = 0; g < 3; g++) begin : g_cross
        localparam int J1 = (g + 1) % 3;
        localparam int J2 = (g + 2) % 3;

        always_comb begin
            w_ops[g].m1 = X_W'(r_m2[J1]);
            w_ops[g].m2 = X_W'(r_m2[J2]);
            w_ops[g].e1 = X_W'(r_e2[J1]);
            w_ops[g].e2 = X_W'(r_e2[J2]);
            w_ops[g].d1 = Y_W'(r_d2[J1]);
            w_ops[g].d2 = Y_W'(r_d2[J2]);
            w_ops[g].a1 = $signed(Y_W'(r_a2[J1]));
            w_ops[g].a2 = $signed(Y_W'(r_a2[J2]));
        end

        sbot_cross u_cross (
            .i_clk (i_clk),
            .i_en  (w_stage_en),
            .i_ops (w_ops[g]),
            .o_sep (w_sep[g])
        );
    end

    // stage 7: output register
    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_ovl <= !(r_face[6] || (|w_sep));
        end
    end

    assign m_axis_tvalid = r_vld[N_STAGES];
    assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, r_ovl};

endmodule

/* rtl/sbot_cross.sv */
// sbot_cross: one cross-axis separation test, four register stages
// (split partial products, products, both sides, magnitude compare); uses sbot_pkg
module sbot_cross (
    input  logic                   i_clk,
    input  sbot_pkg::t_stage_en    i_en,
    input  sbot_pkg::t_cross_ops   i_ops,
    output logic                   o_sep
);
    import sbot_pkg::*;

    logic signed [X_W-1:0]    w_x [4];
    logic signed [Y_W-1:0]    w_y [4];
    logic signed [X_W+LO_W:0] r_pl [4];
    logic signed [X_W+HI_W-1:0] r_ph [4];
    logic signed [P_W-1:0]    r_prod [4];
    logic signed [S_W-1:0]    r_lhs;
    logic signed [S_W-1:0]    r_rhs;
    logic        [S_W-1:0]    w_lhs_abs;
    logic                     r_sep;

    // products m1*d2, m2*d1 on the left, e1*a2, e2*a1 on the right
    always_comb begin
        w_x[0] = i_ops.m1;  w_y[0] = i_ops.d2;
        w_x[1] = i_ops.m2;  w_y[1] = i_ops.d1;
        w_x[2] = i_ops.e1;  w_y[2] = i_ops.a2;
        w_x[3] = i_ops.e2;  w_y[3] = i_ops.a1;
    end

    // stage 3: partial products against the low and high halves
    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            for (int k = 0; k < 4; k++) begin
                r_pl[k] <= w_x[k] * $signed({1'b0, w_y[k][LO_W-1:0]});
                r_ph[k] <= w_x[k] * $signed(w_y[k][Y_W-1:LO_W]);
            end
        end
    end

    // stage 4: recombine halves into full products
    always_ff @(posedge i_clk) begin
        if (i_en.en4) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= (P_W'(r_ph[k]) <<< LO_W) + P_W'(r_pl[k]);
            end
        end
    end

    // stage 5: left side difference, right side sum
    always_ff @(posedge i_clk) begin
        if (i_en.en5) begin
            r_lhs <= S_W'(r_prod[0]) - S_W'(r_prod[1]);
            r_rhs <= S_W'(r_prod[2]) + S_W'(r_prod[3]);
        end
    end

    // stage 6: separated when |lhs| strictly exceeds rhs
    assign w_lhs_abs = r_lhs[S_W-1] ? S_W'(-r_lhs) : S_W'(r_lhs);

    always_ff @(posedge i_clk) begin
        if (i_en.en6) begin
            r_sep <= $signed({1'b0, w_lhs_abs}) > $signed({r_rhs[S_W-1], r_rhs});
        end
    end

    assign o_sep = r_sep;

endmodule

/* tb/tb_segment_box_overlap_test.sv */
// tb_segment_box_overlap_test: self-checking testbench for the segment/box overlap test
// directed table then random geometry under several margin settings; needs sbot_pkg
// and segment_box_overlap_test
`timescale 1ns / 1ps

module tb_segment_box_overlap_test;

    import sbot_pkg::*;

    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 160;
    localparam int SETTLE_WAIT  = 20;
    localparam int CALM_ITEMS   = 30;

    // one request: x in the lowest word of each corner, seg_start in the lowest bits
    typedef logic [2:0][FIELD_W-1:0] t_vec;
    typedef struct packed {
        t_vec box_hi;
        t_vec box_lo;
        t_vec seg_end;
        t_vec seg_start;
    } t_query;

    typedef struct {
        t_query q;
        bit     pinned;
        bit     want;
    } t_row;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [MARGIN_W-1:0] i_cfg_data    = '0;

    // typed-in answer travelling with the current request
    logic                pin_valid     = 1'b0;
    logic                pin_want      = 1'b0;

    logic [MARGIN_W-1:0] margin_q      = 16'd1;
    bit                  pending_overlaps[$];
    t_row                dir_rows[$];
    int unsigned         n_queries     = 0;
    int unsigned         n_results     = 0;
    int unsigned         n_hits        = 0;
    int unsigned         n_margins     = 0;
    int unsigned         n_errors      = 0;
    int unsigned         stall_cycles  = 0;
    bit                  held          = 1'b0;
    bit                  calm          = 1'b1;

    segment_box_overlap_test dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // one cross-axis test, exact in 128 bits
    function automatic bit cross_apart(longint m1, longint m2, longint d1, longint d2,
                                       longint e1, longint e2, longint a1, longint a2);
        logic signed [127:0] wm1, wm2, wd1, wd2, we1, we2, wa1, wa2, lhs, rhs;
        wm1 = m1; wm2 = m2; wd1 = d1; wd2 = d2;
        we1 = e1; we2 = e2; wa1 = a1; wa2 = a2;
        lhs = wm1 * wd2 - wm2 * wd1;
        rhs = we1 * wa2 + we2 * wa1;
        if (lhs < 0)
            lhs = -lhs;
        return lhs > rhs;
    endfunction

    // separating-axis answer on doubled quantities
    function automatic bit overlap_of(t_query q, logic [MARGIN_W-1:0] mg);
        longint m[3], d[3], e[3], a[3];
        longint s, t, lo, hi;
        bit     apart;
        apart = 1'b0;
        for (int i = 0; i < 3; i++) begin
            s  = $signed(q.seg_start[i]);
            t  = $signed(q.seg_end[i]);
            lo = $signed(q.box_lo[i]);
            hi = $signed(q.box_hi[i]);
            m[i] = s + t - lo - hi;
            d[i] = t - s;
            e[i] = hi - lo;
            a[i] = (d[i] < 0) ? -d[i] : d[i];
            if (((m[i] < 0) ? -m[i] : m[i]) > e[i] + a[i])
                apart = 1'b1;
            a[i] = a[i] + longint'(mg);
        end
        if (!apart)
            apart = cross_apart(m[1], m[2], d[1], d[2], e[1], e[2], a[1], a[2])
                 || cross_apart(m[2], m[0], d[2], d[0], e[2], e[0], a[2], a[0])
                 || cross_apart(m[0], m[1], d[0], d[1], e[0], e[1], a[0], a[1]);
        return !apart;
    endfunction

    function automatic t_query mk(int sx, int sy, int sz, int ex, int ey, int ez,
                                  int lx, int ly, int lz, int hx, int hy, int hz);
        t_query q;
        q.seg_start = {sz, sy, sx};
        q.seg_end   = {ez, ey, ex};
        q.box_lo    = {lz, ly, lx};
        q.box_hi    = {hz, hy, hx};
        return q;
    endfunction

    function automatic logic [FIELD_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // signed random of magnitude up to 2**sc
    function automatic longint spread(int unsigned sc);
        longint r;
        r = longint'($signed($urandom));
        return r >>> (31 - sc);
    endfunction

    // random geometry: mostly a box with a segment around it, some noise and odd cases
    function automatic t_query gen_query();
        t_query      q;
        int unsigned sc, kind, k;
        longint      cen, half;
        sc   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 30);
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            cen  = spread(30);
            half = spread(sc);
            if (half < 0)
                half = -half;
            q.box_lo[i]    = clamp32(cen - half);
            q.box_hi[i]    = clamp32(cen + half);
            q.seg_start[i] = clamp32(cen + spread(sc + 1));
            q.seg_end[i]   = clamp32(cen + spread(sc + 1));
        end
        k = $urandom_range(0, 2);
        if (kind < 10) begin
            // noise over the full field range
            for (int i = 0; i < 3; i++) begin
                q.box_lo[i]    = $urandom;
                q.box_hi[i]    = $urandom;
                q.seg_start[i] = $urandom;
                q.seg_end[i]   = $urandom;
            end
        end else if (kind < 15) begin
            // inverted box on one axis
            {q.box_lo[k], q.box_hi[k]} = {q.box_hi[k], q.box_lo[k]};
        end else if (kind < 20) begin
            // point query
            q.seg_end = q.seg_start;
        end else if (kind < 28) begin
            // segment starting on a face and leaving outward
            half = spread(sc);
            if (half < 0)
                half = -half;
            q.seg_start[k] = q.box_hi[k];
            q.seg_end[k]   = clamp32(longint'($signed(q.box_hi[k])) + half);
        end
        return q;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_query(t_query q, bit pinned, bit want);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = q;
        pin_valid     = pinned;
        pin_want      = want;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        pin_valid     = 1'b0;
        while (pending_overlaps.size() != 0)
            @(posedge i_clk);
    endtask

    // margin write, only with the pipeline empty
    task automatic write_margin(logic [MARGIN_W-1:0] value);
        wait_drained();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic add_row(t_query q, bit pinned, bit want);
        t_row r;
        r.q      = q;
        r.pinned = pinned;
        r.want   = want;
        dir_rows.push_back(r);
    endtask

    task automatic build_rows();
        // point at the origin in a zero box: touching everywhere
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1);
        // everything at the top and at the bottom of the range
        add_row(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h7FFFFFFF), 1'b1, 1'b1);
        add_row(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000), 1'b1, 1'b1);
        // point outside a small box
        add_row(mk(0, 0, 0, 0, 0, 0, 1, 1, 1, 2, 2, 2), 1'b1, 1'b0);
        // inverted box on every axis, and on one axis only
        add_row(mk(0, 0, 0, 0, 0, 0, 1, 1, 1, -1, -1, -1), 1'b1, 1'b0);
        add_row(mk(-3, 0, 0, 3, 0, 0, -1, 5, -5, 1, -5, 5), 1'b0, 1'b0);
        // full-range segment through a small box
        add_row(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, -1, -1, -1, 1, 1, 1), 1'b0, 1'b0);
        add_row(mk(32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h80000000,
                   -1, -1, -1, 1, 1, 1), 1'b0, 1'b0);
        // full-range box around an arbitrary segment
        add_row(mk(12345, -777, 9, -4000000, 65536, 3, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b1, 1'b1);
        // diagonal through the box
        add_row(mk(-10, -10, 0, 10, 10, 0, -1, -1, -1, 1, 1, 1), 1'b0, 1'b0);
        // skew segment passing a box edge, only a cross axis separates
        add_row(mk(-3, 1, 0, 1, 3, 0, -1, -1, -1, 1, 1, 1), 1'b0, 1'b0);
        add_row(mk(-2, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0);
        add_row(mk(-2, 1, 5, 1, -2, -5, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0);
        // endpoint exactly on a face, then one step off it
        add_row(mk(1, 0, 0, 5, 0, 0, -1, -1, -1, 1, 1, 1), 1'b1, 1'b1);
        add_row(mk(2, 0, 0, 5, 0, 0, -1, -1, -1, 1, 1, 1), 1'b1, 1'b0);
        // point inside and point on a corner
        add_row(mk(0, 0, 0, 0, 0, 0, -5, -5, -5, 5, 5, 5), 1'b1, 1'b1);
        add_row(mk(5, 5, 5, 5, 5, 5, -5, -5, -5, 5, 5, 5), 1'b1, 1'b1);
        // segment wholly inside a fractional box
        add_row(mk(-32768, 100, 0, 32768, -100, 7, -65536, -65536, -65536, 65536, 65536,
                   65536), 1'b0, 1'b0);
    endtask

    // request/result bookkeeping and comparison at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (pending_overlaps.size() == 0) begin
                    n_errors++;
                    $display("%0t: result %02h with no request pending", $time, m_axis_tdata);
                end else begin
                    if (m_axis_tdata != {7'b0, pending_overlaps[0]}) begin
                        n_errors++;
                        $display("%0t: overlaps mismatch, expected %02h actual %02h",
                                 $time, {7'b0, pending_overlaps[0]}, m_axis_tdata);
                    end
                    if (pending_overlaps[0])
                        n_hits++;
                    void'(pending_overlaps.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n_queries++;
                pending_overlaps.push_back(pin_valid ? pin_want
                                                     : overlap_of(t_query'(s_axis_tdata),
                                                                  margin_q));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                margin_q = i_cfg_data;
                n_margins++;
            end
        end
    end

    // watchdog on cycles with no accepted transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random back-pressure, clean stretches, one long hold-off
    initial begin
        int unsigned stall_left, free_left, r;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge i_clk);
            if (!held && n_results >= 200) begin
                held          = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (stall_left != 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (free_left != 0) begin
                m_axis_tready = 1'b1;
                free_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    stall_left    = $urandom_range(10, 40);
                    m_axis_tready = 1'b0;
                end else if (r < 6) begin
                    free_left     = $urandom_range(20, 60);
                    m_axis_tready = 1'b1;
                end else begin
                    m_axis_tready = (r >= 30);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [MARGIN_W-1:0] margins[4];
        margins[0] = 16'd0;
        margins[1] = 16'hFFFF;
        margins[2] = 16'($urandom_range(2, 65534));
        margins[3] = 16'd1;
        build_rows();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table at the reset margin
        calm = 1'b1;
        foreach (dir_rows[i])
            send_query(dir_rows[i].q, dir_rows[i].pinned, dir_rows[i].want);

        // random phases, one per margin setting
        foreach (margins[p]) begin
            write_margin(margins[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                calm = (n < CALM_ITEMS);
                send_query(gen_query(), 1'b0, 1'b0);
            end
        end

        wait_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (pending_overlaps.size() != 0) begin
            n_errors++;
            $display("%0t: %0d results never arrived", $time, pending_overlaps.size());
        end
        $display("ran %0d queries (%0d directed), %0d found overlapping, %0d separated",
                 n_queries, dir_rows.size(), n_hits, n_results - n_hits);
        $display("margin written %0d times incl. 0 and 65535, one long result hold-off",
                 n_margins);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
